// ===== hdl/pfsp_pkg.sv =====
// Package for the printf conversion specifier parser.
// Character codes, mask bit positions, parser phase codes and the digit accumulate helper.
// No dependencies.
package pfsp_pkg;

	typedef logic        [7:0]  char_t;
	typedef logic        [5:0]  mask6_t;
	typedef logic signed [31:0] word_t;
	typedef logic        [30:0] uval_t;

	localparam uval_t INT31_MAX = 31'h7FFF_FFFF;

	// characters the parser reacts to
	localparam char_t CH_NUL   = 8'h00;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_HASH  = 8'h23;
	localparam char_t CH_PLUS  = 8'h2B;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_DOT   = 8'h2E;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_ONE   = 8'h31;
	localparam char_t CH_NINE  = 8'h39;
	localparam char_t CH_UC_C  = 8'h43;
	localparam char_t CH_UC_D  = 8'h44;
	localparam char_t CH_UC_O  = 8'h4F;
	localparam char_t CH_UC_S  = 8'h53;
	localparam char_t CH_UC_U  = 8'h55;
	localparam char_t CH_C     = 8'h63;
	localparam char_t CH_D     = 8'h64;
	localparam char_t CH_H     = 8'h68;
	localparam char_t CH_I     = 8'h69;
	localparam char_t CH_J     = 8'h6A;
	localparam char_t CH_L     = 8'h6C;
	localparam char_t CH_P     = 8'h70;
	localparam char_t CH_S     = 8'h73;
	localparam char_t CH_Z     = 8'h7A;
	localparam char_t CASE_OFS = 8'h20;

	// flag mask bits
	localparam int FL_ALT   = 0;
	localparam int FL_ZERO  = 1;
	localparam int FL_MINUS = 2;
	localparam int FL_DOT   = 3;
	localparam int FL_SPACE = 4;
	localparam int FL_PLUS  = 5;

	// length mask bits
	localparam int LN_HH = 0;
	localparam int LN_H  = 1;
	localparam int LN_L  = 2;
	localparam int LN_LL = 3;
	localparam int LN_J  = 4;
	localparam int LN_Z  = 5;

	// digit run phase
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_WIDTH = 2'd1;
	localparam logic [1:0] PH_PREC  = 2'd2;

	// pending size mark
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_H    = 2'd1;
	localparam logic [1:0] PEND_L    = 2'd2;

	localparam logic [7:0] CNT_MAX = 8'd255;

	// acc*10 + d, saturated to 2^31-1 (shift-add, no multiplier)
	function automatic uval_t add_digit(input uval_t acc, input logic [3:0] d);
		logic [34:0] sum;
		sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, d};
		if (sum > {4'd0, INT31_MAX})
			return INT31_MAX;
		return sum[30:0];
	endfunction

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == CNT_MAX) ? v : v + 8'd1;
	endfunction

endpackage

// ===== hdl/printf_spec_parser.sv =====
// Top level of the printf conversion specifier parser.
// Input register, per-character parse update and the descriptor output register.
// Depends on pfsp_pkg.
//
// Usage:
//   Characters of a format string, starting after the percent sign, arrive on
//   the item channel (item_valid/item_ready, payload ch and first). Setting
//   first clears the parse state before that character is applied. Each
//   transfer is one character; a NUL or a character outside "#0-. +hljz" and
//   not part of a digit run ends the specifier and yields one descriptor on
//   the desc channel (desc_valid/desc_ready). Other characters yield nothing.
//   Throughput: one character per cycle, sustained while no ending character
//   waits on a full descriptor register, including the character that ends
//   a specifier. Path: a transfer lands in the input register when accepted;
//   from there it is applied to the parse state and, when it ends the specifier,
//   loads the descriptor register, which drives desc_valid.
//   When the receiver stalls, the descriptor waits in its register and the
//   input register keeps taking characters that produce no descriptor; a
//   second ending character holds in the input register until the first
//   descriptor is taken. Reset (arst_n low) empties both registers and
//   returns the parse state to its initial values (precision -1, count 1).
module printf_spec_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  pfsp_pkg::char_t     ch,
	input  logic                first,
	output logic                desc_valid,
	input  logic                desc_ready,
	output pfsp_pkg::char_t     conversion,
	output pfsp_pkg::mask6_t    flag_mask,
	output pfsp_pkg::mask6_t    length_mask,
	output pfsp_pkg::word_t     field_width,
	output pfsp_pkg::word_t     precision_out,
	output logic [7:0]          consumed,
	output logic                ended_early
);
	import pfsp_pkg::*;

	// input register
	logic  valid_s1;
	char_t ch_s1;
	logic  first_s1;

	// parse state
	mask6_t     flag_q, len_q;
	uval_t      width_q;
	word_t      prec_q;
	logic [1:0] phase_q, pend_q;
	logic       pdot_q;
	logic [7:0] cnt_q;

	// descriptor register
	logic       out_valid_q;
	char_t      conv_q;
	mask6_t     fmask_q, lmask_q;
	word_t      fwidth_q, prec_out_q;
	logic [7:0] consumed_q;
	logic       early_q;

	// next state and result
	mask6_t     flag_d, len_d;
	uval_t      width_d;
	word_t      prec_d;
	logic [1:0] phase_d, pend_d;
	logic       pdot_d;
	logic [7:0] cnt_d;
	logic       emit;
	char_t      r_conv;
	mask6_t     r_flags, r_len;
	word_t      r_width;
	logic [7:0] r_cnt;

	logic out_free, s1_go;

	assign out_free   = !out_valid_q || desc_ready;
	// the staged character moves on unless it ends a spec and the descriptor slot is full and not being taken
	assign s1_go      = valid_s1 && (!emit || out_free);
	assign item_ready = !valid_s1 || s1_go;

	always_comb begin
		mask6_t      f, l;
		uval_t       w;
		word_t       p;
		logic [1:0]  ph, pd;
		logic        dt;
		logic [7:0]  cn;
		logic        done;
		logic        in_set;
		logic [33:0] wsum;
		char_t       c;

		c  = ch_s1;
		f  = first_s1 ? '0 : flag_q;
		l  = first_s1 ? '0 : len_q;
		w  = first_s1 ? '0 : width_q;
		p  = first_s1 ? -32'sd1 : prec_q;
		ph = first_s1 ? PH_IDLE : phase_q;
		pd = first_s1 ? PEND_NONE : pend_q;
		dt = first_s1 ? 1'b0 : pdot_q;
		cn = first_s1 ? 8'd1 : cnt_q;

		done = 1'b0;
		emit = 1'b0;
		in_set = c inside {CH_HASH, CH_ZERO, CH_MINUS, CH_DOT, CH_SPACE, CH_PLUS,
		                   CH_H, CH_L, CH_J, CH_Z};

		// a waiting h or l either pairs with this character or is set alone
		if (pd != PEND_NONE) begin
			if (c inside {CH_H, CH_L}) begin
				if (pd == PEND_H)
					l[LN_HH] = 1'b1;
				else
					l[LN_LL] = 1'b1;
				dt   = 1'b0;
				done = 1'b1;
			end else if (pd == PEND_H) begin
				l[LN_H] = 1'b1;
			end else begin
				l[LN_L] = 1'b1;
			end
			pd = PEND_NONE;
		end

		if (!done && ph != PH_IDLE) begin
			if (c inside {[CH_ZERO:CH_NINE]}) begin
				if (ph == PH_WIDTH)
					w = add_digit(w, c[3:0]);
				else
					p = {1'b0, add_digit(p[30:0], c[3:0])};
				dt   = 1'b0;
				done = 1'b1;
			end else begin
				ph = PH_IDLE;
			end
		end

		if (!done && (c inside {[CH_ONE:CH_NINE]})) begin
			if (p[31] && !dt) begin
				ph = PH_WIDTH;
				w  = {27'd0, c[3:0]};
			end else begin
				ph = PH_PREC;
				p  = {28'd0, c[3:0]};
			end
			dt   = 1'b0;
			done = 1'b1;
		end

		if (!done) begin
			if (c == CH_NUL || !in_set) begin
				emit = 1'b1;
			end else begin
				case (c)
					CH_HASH:  f[FL_ALT]   = 1'b1;
					CH_ZERO:  f[FL_ZERO]  = 1'b1;
					CH_MINUS: f[FL_MINUS] = 1'b1;
					CH_DOT:   f[FL_DOT]   = 1'b1;
					CH_SPACE: f[FL_SPACE] = 1'b1;
					CH_PLUS:  f[FL_PLUS]  = 1'b1;
					CH_H:     pd = PEND_H;
					CH_L:     pd = PEND_L;
					CH_J:     l[LN_J] = 1'b1;
					default:  l[LN_Z] = 1'b1;
				endcase
				dt = (c == CH_DOT);
			end
		end

		// descriptor: flag conflicts, then conversion normalization
		r_width = {1'b0, w};
		r_flags = f;
		r_len   = l;
		if (&f) begin
			r_flags[FL_DOT] = 1'b0;
			// range is -4 .. 2^32-5, only the top needs a clamp
			wsum = {3'b000, w} + {{2{p[31]}}, p} - 34'sd3;
			if ($signed(wsum) > $signed({3'b000, INT31_MAX}))
				r_width = {1'b0, INT31_MAX};
			else
				r_width = wsum[31:0];
		end
		if (r_flags[FL_PLUS] && r_flags[FL_SPACE])
			r_flags[FL_SPACE] = 1'b0;
		if (r_flags[FL_ZERO] && (r_flags[FL_DOT] || r_flags[FL_MINUS]))
			r_flags[FL_ZERO] = 1'b0;

		r_conv = c;
		if (c == CH_I)
			r_conv = CH_D;
		else if (l[LN_L] && c == CH_C)
			r_conv = CH_UC_C;
		else if (l[LN_L] && c == CH_S)
			r_conv = CH_UC_S;
		else if (c inside {CH_UC_U, CH_UC_D, CH_UC_O}) begin
			r_len[LN_L] = 1'b1;
			r_conv      = c + CASE_OFS;
		end
		if (c == CH_P)
			r_flags[FL_ALT] = 1'b1;
		r_cnt = (c != CH_NUL) ? sat_inc(cn) : cn;

		// an ending character resets the parse state; every other character counts once, saturating at 255
		if (emit) begin
			flag_d  = '0;
			len_d   = '0;
			width_d = '0;
			prec_d  = -32'sd1;
			phase_d = PH_IDLE;
			pend_d  = PEND_NONE;
			pdot_d  = 1'b0;
			cnt_d   = 8'd1;
		end else begin
			flag_d  = f;
			len_d   = l;
			width_d = w;
			prec_d  = p;
			phase_d = ph;
			pend_d  = pd;
			pdot_d  = dt;
			cnt_d   = sat_inc(cn);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			ch_s1    <= ch;
			first_s1 <= first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q  <= '0;
			len_q   <= '0;
			width_q <= '0;
			prec_q  <= -32'sd1;
			phase_q <= PH_IDLE;
			pend_q  <= PEND_NONE;
			pdot_q  <= 1'b0;
			cnt_q   <= 8'd1;
		end else if (s1_go) begin
			flag_q  <= flag_d;
			len_q   <= len_d;
			width_q <= width_d;
			prec_q  <= prec_d;
			phase_q <= phase_d;
			pend_q  <= pend_d;
			pdot_q  <= pdot_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && emit) begin
			out_valid_q <= 1'b1;
		end else if (desc_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit) begin
			conv_q     <= r_conv;
			fmask_q    <= r_flags;
			lmask_q    <= r_len;
			fwidth_q   <= r_width;
			// an ending character never touches the precision
			prec_out_q <= first_s1 ? -32'sd1 : prec_q;
			consumed_q <= r_cnt;
			early_q    <= (ch_s1 == CH_NUL);
		end
	end

	assign desc_valid    = out_valid_q;
	assign conversion    = conv_q;
	assign flag_mask     = fmask_q;
	assign length_mask   = lmask_q;
	assign field_width   = fwidth_q;
	assign precision_out = prec_out_q;
	assign consumed      = consumed_q;
	assign ended_early   = early_q;

endmodule

// ===== tb/sv/tb_printf_spec_parser.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for printf_spec_parser: format characters in, descriptors out.
// Uses types and character codes from pfsp_pkg; needs only the RTL.

module tb_printf_spec_parser;
	import pfsp_pkg::*;

	localparam int      CLK_HALF    = 4;
	localparam int      RESET_CYCLES = 10;
	localparam int      ITEM_TARGET = 1850;
	localparam int      CYCLE_LIMIT = 400000;
	localparam int      MAX_REPORTS = 40;
	localparam longint  SAT_HI      = 64'sd2147483647;
	localparam longint  SAT_LO      = -64'sd2147483648;

	// receiver stall patterns
	typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	// one character transfer as queued for the driver
	typedef struct {
		char_t code;
		logic  lead;
	} char_xfer_t;

	// one descriptor as predicted
	typedef struct {
		char_t      conv;
		mask6_t     flags;
		mask6_t     lens;
		word_t      width;
		word_t      prec;
		logic [7:0] count;
		logic       early;
	} desc_t;

	logic       clk;
	logic       arst_n;
	logic       item_valid = 1'b0;
	logic       item_ready;
	char_t      ch         = CH_NUL;
	logic       first      = 1'b0;
	logic       desc_valid;
	logic       desc_ready = 1'b0;
	char_t      conversion;
	mask6_t     flag_mask;
	mask6_t     length_mask;
	word_t      field_width;
	word_t      precision_out;
	logic [7:0] consumed;
	logic       ended_early;

	printf_spec_parser uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.ch           (ch),
		.first        (first),
		.desc_valid   (desc_valid),
		.desc_ready   (desc_ready),
		.conversion   (conversion),
		.flag_mask    (flag_mask),
		.length_mask  (length_mask),
		.field_width  (field_width),
		.precision_out(precision_out),
		.consumed     (consumed),
		.ended_early  (ended_early)
	);

	char_xfer_t char_queue[$];     // characters still to be sent
	desc_t      desc_expected[$];  // descriptors predicted, not yet seen
	int         item_total  = 0;
	logic       next_first  = 1'b0;
	int         err_count   = 0;
	int         desc_count  = 0;
	int         cycle_count = 0;
	logic       xfer_done   = 1'b0;

	string flag_set = "#0-. +";
	string len_set  = "hljz";
	string conv_set = "dicsuxXpUDOfegn%CS";

	//------------------------------------------------------------------
	// Spec parser prediction. Mirrors the block's parse state; updated
	// once per accepted character, pushes a descriptor when a spec ends.
	//------------------------------------------------------------------
	mask6_t     sp_flags;
	mask6_t     sp_lens;
	longint     sp_width;
	longint     sp_prec;      // -1 until a precision is given
	logic [1:0] sp_phase;     // digit run target
	logic [1:0] sp_pend;      // h or l waiting for its partner
	logic       sp_after_dot;
	logic [7:0] sp_count;     // starts at 1 for the percent sign

	function automatic void spec_reset();
		sp_flags     = '0;
		sp_lens      = '0;
		sp_width     = 0;
		sp_prec      = -1;
		sp_phase     = PH_IDLE;
		sp_pend      = PEND_NONE;
		sp_after_dot = 1'b0;
		sp_count     = 8'd1;
	endfunction

	function automatic void count_up();
		if (sp_count != CNT_MAX)
			sp_count++;
	endfunction

	function automatic longint digit_append(longint acc, char_t c);
		longint v;
		v = acc * 10 + longint'(c - CH_ZERO);
		return (v > SAT_HI) ? SAT_HI : v;
	endfunction

	// end of spec: conflict rules, conversion normalization, emit
	function automatic void close_spec(char_t c);
		desc_t  d;
		mask6_t f;
		mask6_t ln;
		longint w;
		f  = sp_flags;
		ln = sp_lens;
		w  = sp_width;
		// all six flags: drop dot, fold precision into width
		if (&f) begin
			f[FL_DOT] = 1'b0;
			w = w + sp_prec - 3;
			if (w > SAT_HI)
				w = SAT_HI;
			if (w < SAT_LO)
				w = SAT_LO;
		end
		if (f[FL_PLUS] && f[FL_SPACE])
			f[FL_SPACE] = 1'b0;
		if (f[FL_ZERO] && (f[FL_DOT] || f[FL_MINUS]))
			f[FL_ZERO] = 1'b0;
		d.conv = c;
		if (c == CH_I)
			d.conv = CH_D;
		else if (ln[LN_L] && c == CH_C)
			d.conv = CH_UC_C;
		else if (ln[LN_L] && c == CH_S)
			d.conv = CH_UC_S;
		else if (c == CH_UC_U || c == CH_UC_D || c == CH_UC_O) begin
			ln[LN_L] = 1'b1;
			d.conv   = c + CASE_OFS;
		end
		if (c == CH_P)
			f[FL_ALT] = 1'b1;
		d.flags = f;
		d.lens  = ln;
		d.width = word_t'(w);
		d.prec  = word_t'(sp_prec);
		d.count = (c != CH_NUL && sp_count != CNT_MAX) ? sp_count + 8'd1 : sp_count;
		d.early = (c == CH_NUL);
		desc_expected.push_back(d);
		spec_reset();
	endfunction

	function automatic void parse_char(char_t c, logic is_first);
		logic was_h;
		if (is_first)
			spec_reset();
		// resolve a waiting h/l: pairs up or becomes a single mark
		if (sp_pend != PEND_NONE) begin
			was_h   = (sp_pend == PEND_H);
			sp_pend = PEND_NONE;
			if (c == CH_H || c == CH_L) begin
				if (was_h)
					sp_lens[LN_HH] = 1'b1;
				else
					sp_lens[LN_LL] = 1'b1;
				sp_after_dot = 1'b0;
				count_up();
				return;
			end
			if (was_h)
				sp_lens[LN_H] = 1'b1;
			else
				sp_lens[LN_L] = 1'b1;
		end
		// inside a digit run any digit extends it
		if (sp_phase != PH_IDLE) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				if (sp_phase == PH_WIDTH)
					sp_width = digit_append(sp_width, c);
				else
					sp_prec = digit_append(sp_prec, c);
				sp_after_dot = 1'b0;
				count_up();
				return;
			end
			sp_phase = PH_IDLE;
		end
		// new run: precision after a dot or once precision is set
		if (c >= CH_ONE && c <= CH_NINE) begin
			if (sp_prec < 0 && !sp_after_dot) begin
				sp_phase = PH_WIDTH;
				sp_width = longint'(c - CH_ZERO);
			end else begin
				sp_phase = PH_PREC;
				sp_prec  = longint'(c - CH_ZERO);
			end
			sp_after_dot = 1'b0;
			count_up();
			return;
		end
		case (c)
			CH_HASH:  sp_flags[FL_ALT]   = 1'b1;
			CH_ZERO:  sp_flags[FL_ZERO]  = 1'b1;
			CH_MINUS: sp_flags[FL_MINUS] = 1'b1;
			CH_DOT:   sp_flags[FL_DOT]   = 1'b1;
			CH_SPACE: sp_flags[FL_SPACE] = 1'b1;
			CH_PLUS:  sp_flags[FL_PLUS]  = 1'b1;
			CH_H:     sp_pend = PEND_H;
			CH_L:     sp_pend = PEND_L;
			CH_J:     sp_lens[LN_J] = 1'b1;
			CH_Z:     sp_lens[LN_Z] = 1'b1;
			default: begin
				// NUL or anything outside the spec set ends it
				close_spec(c);
				return;
			end
		endcase
		sp_after_dot = (c == CH_DOT);
		count_up();
	endfunction

	//------------------------------------------------------------------
	// Stimulus building
	//------------------------------------------------------------------
	task automatic push_char(char_t c);
		char_queue.push_back('{c, next_first});
		next_first = 1'b0;
		item_total++;
	endtask

	task automatic push_text(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			push_char(char_t'(s[i]));
	endtask

	// digit run: leading 1..9 then any digits
	task automatic push_digits(int len);
		push_char(CH_ONE + char_t'($urandom_range(0, 8)));
		repeat (len - 1)
			push_char(CH_ZERO + char_t'($urandom_range(0, 9)));
	endtask

	function automatic int run_len(logic huge);
		if (huge || $urandom_range(0, 11) == 0)
			return $urandom_range(10, 12);  // can go past 2^31-1
		return $urandom_range(1, 3);
	endfunction

	task automatic gen_spec(logic stretch);
		int   pick;
		int   kind;
		int   rot;
		logic huge;
		char_t m;
		pick = $urandom_range(0, 99);
		// raw noise, random first bits
		if (pick < 10) begin
			repeat ($urandom_range(1, 4)) begin
				next_first = 1'($urandom_range(0, 1));
				push_char(char_t'($urandom_range(0, 255)));
			end
			return;
		end
		next_first = ($urandom_range(0, 7) != 0);
		huge = (pick < 15);
		if (huge) begin
			// every flag in some order; digit runs that follow are long, so width and precision can saturate
			rot = $urandom_range(0, 5);
			for (int i = 0; i < 6; i++)
				push_char(char_t'(flag_set[(rot + i) % 6]));
		end
		if (stretch) begin
			// long, to drive the consumed count toward its saturation
			repeat ($urandom_range(250, 270))
				push_char(char_t'(flag_set[$urandom_range(0, 5)]));
		end
		repeat ($urandom_range(huge ? 2 : 0, 5)) begin
			kind = $urandom_range(0, 9);
			if (kind < 3)
				push_char(char_t'(flag_set[$urandom_range(0, 5)]));
			else if (kind < 5)
				push_digits(run_len(huge));
			else if (kind < 7) begin
				push_char(CH_DOT);
				if ($urandom_range(0, 3) != 0)
					push_digits(run_len(huge));
			end else begin
				m = char_t'(len_set[$urandom_range(0, 3)]);
				push_char(m);
				if ((m == CH_H || m == CH_L) && $urandom_range(0, 2) == 0)
					push_char($urandom_range(0, 1) ? CH_H : CH_L);
			end
		end
		pick = $urandom_range(0, 99);
		if (pick < 8)
			push_char(CH_NUL);
		else if (pick < 75)
			push_char(char_t'(conv_set[$urandom_range(0, conv_set.len() - 1)]));
		else
			push_char(char_t'($urandom_range(0, 255)));  // may continue the spec
	endtask

	//------------------------------------------------------------------
	// Clock, timeout
	//------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	//------------------------------------------------------------------
	// Character side: acceptance is sampled at the rising edge and fed
	// to the prediction; the driver acts on it at the next falling edge.
	//------------------------------------------------------------------
	always @(posedge clk) begin
		xfer_done <= arst_n && item_valid && item_ready;
		if (arst_n && item_valid && item_ready)
			parse_char(ch, first);
	end

	int burst_left = 0;
	int gap_left   = 0;

	// bursts of random length, random gaps between them
	always @(negedge clk) begin
		if (arst_n) begin
			if (xfer_done)
				char_queue.delete(0);
			if (!item_valid || xfer_done) begin
				if (gap_left != 0 || char_queue.size() == 0) begin
					item_valid <= 1'b0;
					if (gap_left != 0)
						gap_left--;
				end else begin
					item_valid <= 1'b1;
					ch         <= char_queue[0].code;
					first      <= char_queue[0].lead;
					if (burst_left > 1)
						burst_left--;
					else begin
						burst_left = $urandom_range(1, 48);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end
				end
			end
		end
	end

	//------------------------------------------------------------------
	// Descriptor side
	//------------------------------------------------------------------
	rx_mode_t rx_mode     = RX_OPEN;
	int       rx_left     = 0;
	int       hold_left   = 0;
	logic     hold_taken  = 1'b0;

	// stall pattern; one long hold-off so the block backs up into its input
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left--;
				desc_ready <= 1'b0;
			end else if (!hold_taken && desc_count >= 100) begin
				hold_taken = 1'b1;
				hold_left  = 600;
				desc_ready <= 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_left = $urandom_range(10, 80);
				end else
					rx_left--;
				case (rx_mode)
					RX_OPEN:   desc_ready <= 1'b1;
					RX_MOSTLY: desc_ready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: desc_ready <= ($urandom_range(0, 3) == 0);
					default:   desc_ready <= ~desc_ready;
				endcase
			end
		end
	end

	function automatic void check_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
		if (want !== got) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : desc_monitor
		desc_t want;
		if (arst_n && desc_valid && desc_ready) begin
			desc_count++;
			if (desc_expected.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t: unexpected descriptor, expected none, got conversion %0d",
						$time, conversion);
			end else begin
				want = desc_expected.pop_front();
				check_field("conversion", want.conv, conversion);
				check_field("flag_mask", want.flags, flag_mask);
				check_field("length_mask", want.lens, length_mask);
				check_field("field_width", want.width, field_width);
				check_field("precision_out", want.prec, precision_out);
				check_field("consumed", want.count, consumed);
				check_field("ended_early", want.early, ended_early);
			end
		end
	end

	//------------------------------------------------------------------
	// Sequence: build stimulus, reset, drain, verdict
	//------------------------------------------------------------------
	initial begin : run_sequence
		int stretch_at;
		arst_n     = 1'b0;
		spec_reset();

		// directed: all flags with no width (width goes to -4), i to d
		next_first = 1'b1;
		push_text("#0-. +i");
		// hh then l, lc to C
		next_first = 1'b1;
		push_text("hhlc");
		// plus drops space, ls to S
		next_first = 1'b1;
		push_text(" +ls");
		// minus drops zero, U to u with l
		next_first = 1'b1;
		push_text("-0U");
		// no first bit: a new spec starts after a result anyway; p sets alt
		push_text("p");
		// pending h settles at end of string
		next_first = 1'b1;
		push_text("h");
		push_char(CH_NUL);
		// first bit mid-spec throws away the width already read
		next_first = 1'b1;
		push_text("#12");
		next_first = 1'b1;
		push_text(".5zO");
		// top byte value as conversion
		push_char(8'hFF);

		// random part; one very long spec somewhere in it
		stretch_at = $urandom_range(200, 1500);
		while (item_total < ITEM_TARGET) begin
			gen_spec(stretch_at >= 0 && item_total >= stretch_at);
			if (item_total >= stretch_at)
				stretch_at = -1;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (char_queue.size() != 0 || item_valid)
			@(posedge clk);
		while (desc_expected.size() != 0)
			@(posedge clk);
		// the descriptor register loads when the ending character leaves the input register
		repeat (8) @(posedge clk);

		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
